/* rtl/core/tcw_pkg.sv */
`default_nettype none
package tcw_pkg;

    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 2 * CHAR_W;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NL       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;

    localparam int TAB_SHIFT = 3;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CC_PRINT = 3'd0,
        CC_NL    = 3'd1,
        CC_CR    = 3'd2,
        CC_BS    = 3'd3,
        CC_ESC   = 3'd4,
        CC_TAB   = 3'd5
    } t_cls;

    typedef struct packed {
        t_op               op;
        t_cls              cls;
        logic [CHAR_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_cmd;

endpackage
`default_nettype wire

/* rtl/core/tcw_front.sv */
`default_nettype none
module tcw_front #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [tcw_pkg::KIND_W-1:0] i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]  i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]  i_read_col,
    input  logic                      i_q_full,
    output logic                      o_push,
    output tcw_pkg::t_cmd             o_cmd
);
    import tcw_pkg::*;

    logic w_in_range;

    assign w_in_range = (i_read_row < ROW_W'(ROWS)) &&
                        ({1'b0, i_read_col} < (COL_W + 1)'(COLS));

    always_comb begin
        o_cmd.code = i_char_code;
        o_cmd.row  = i_read_row;
        o_cmd.col  = i_read_col;
        case (i_kind)
            KIND_PUT:   o_cmd.op = OP_PUT;
            KIND_READ:  o_cmd.op = w_in_range ? OP_READ : OP_NOP;
            KIND_CLEAR: o_cmd.op = OP_CLEAR;
            default:    o_cmd.op = OP_NOP;
        endcase
        case (i_char_code)
            CH_NL:   o_cmd.cls = CC_NL;
            CH_CR:   o_cmd.cls = CC_CR;
            CH_BS:   o_cmd.cls = CC_BS;
            CH_ESC:  o_cmd.cls = CC_ESC;
            CH_TAB:  o_cmd.cls = CC_TAB;
            default: o_cmd.cls = CC_PRINT;
        endcase
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule
`default_nettype wire

/* rtl/core/tcw_queue.sv */
`default_nettype none
module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    t_cmd              r_slots [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slots[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/tcw_back.sv */
`default_nettype none
module tcw_back #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    output logic                       o_q_pop,
    input  tcw_pkg::t_cmd              i_cmd,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tcw_pkg::CHAR_W-1:0] o_cell_char,
    output logic [tcw_pkg::CHAR_W-1:0] o_cell_attr,
    output logic [tcw_pkg::ROW_W-1:0]  o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]  o_cursor_col
);
    import tcw_pkg::*;

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_RDWT = 6'b000100,
        S_SCRL = 6'b001000,
        S_FILL = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [ROW_W-1:0]    r_top, n_top;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [CHAR_W-1:0]   r_attr, n_attr;
    logic                r_esc, n_esc;
    logic [AW-1:0]       r_fill, n_fill;
    logic [AW-1:0]       r_last, n_last;
    logic [CHAR_W-1:0]   r_rch, n_rch;
    logic [CHAR_W-1:0]   r_rat, n_rat;
    logic [CELL_W-1:0]   r_rdata;
    logic [CELL_W-1:0]   r_cells [CELLS];

    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic [CHAR_W-1:0]   r_out_attr;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;

    logic [ROW_W-1:0]    a_row;
    logic [COL_W-1:0]    a_col;
    logic [ROW_W:0]      w_sum;
    logic [ROW_W-1:0]    w_phys;
    logic [AW-1:0]       w_addr;
    logic [COL_W:0]      w_col_inc;
    logic [COL_W:0]      w_col_tab;
    logic                w_last_row;
    logic                w_nl;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [CELL_W-1:0]   w_wdata;
    logic                w_emit;

    // screen row to physical cell address
    assign w_sum  = {1'b0, r_top} + {1'b0, a_row};
    assign w_phys = (w_sum >= (ROW_W + 1)'(ROWS)) ?
                    ROW_W'(w_sum - (ROW_W + 1)'(ROWS)) : w_sum[ROW_W-1:0];
    assign w_addr = AW'(w_phys) * AW'(COLS) + AW'(a_col);

    assign w_col_inc  = {1'b0, r_col} + (COL_W + 1)'(1);
    assign w_col_tab  = (COL_W + 1)'(((({1'b0, r_col} >> TAB_SHIFT) + (COL_W + 1)'(1))
                        << TAB_SHIFT));
    assign w_last_row = ({1'b0, r_row} + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(ROWS);

    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_top   = r_top;
        n_row   = r_row;
        n_col   = r_col;
        n_attr  = r_attr;
        n_esc   = r_esc;
        n_fill  = r_fill;
        n_last  = r_last;
        n_rch   = r_rch;
        n_rat   = r_rat;
        o_q_pop = 1'b0;
        a_row   = r_row;
        a_col   = r_col;
        w_nl    = 1'b0;
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wdata = {r_attr, CH_SPACE};
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rch   = '0;
                n_rat   = '0;
                n_state = S_EMIT;
                case (r_cmd.op)
                    OP_READ: begin
                        a_row   = r_cmd.row;
                        a_col   = r_cmd.col;
                        n_state = S_RDWT;
                    end
                    OP_CLEAR: begin
                        n_fill  = '0;
                        n_last  = AW'(CELLS - 1);
                        n_top   = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_state = S_FILL;
                    end
                    OP_PUT: begin
                        if (r_esc) begin
                            n_attr = r_cmd.code;
                            n_esc  = 1'b0;
                        end else begin
                            case (r_cmd.cls)
                                CC_NL: w_nl = 1'b1;
                                CC_CR: n_col = '0;
                                CC_BS: begin
                                    if (r_col != '0) begin
                                        a_col = r_col - COL_W'(1);
                                        n_col = r_col - COL_W'(1);
                                        w_we  = 1'b1;
                                    end
                                end
                                CC_ESC: n_esc = 1'b1;
                                CC_TAB: begin
                                    if (w_col_tab >= (COL_W + 1)'(COLS)) begin
                                        w_nl = 1'b1;
                                    end else begin
                                        n_col = w_col_tab[COL_W-1:0];
                                    end
                                end
                                default: begin
                                    w_we    = 1'b1;
                                    w_wdata = {r_attr, r_cmd.code};
                                    if (w_col_inc >= (COL_W + 1)'(COLS)) begin
                                        w_nl = 1'b1;
                                    end else begin
                                        n_col = w_col_inc[COL_W-1:0];
                                    end
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
                if (w_nl) begin
                    n_col = '0;
                    if (w_last_row) begin
                        n_row   = ROW_W'(ROWS - 1);
                        n_state = S_SCRL;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
            end
            S_SCRL: begin
                // old top row becomes the new bottom row
                a_row   = '0;
                a_col   = '0;
                n_fill  = w_addr;
                n_last  = w_addr + AW'(COLS - 1);
                n_top   = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + ROW_W'(1);
                n_state = S_FILL;
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_fill;
                if (r_fill == r_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_fill = r_fill + AW'(1);
                end
            end
            S_RDWT: begin
                n_rch   = r_rdata[CHAR_W-1:0];
                n_rat   = r_rdata[CELL_W-1:CHAR_W];
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_attr  <= RESET_COLOR;
            r_esc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_row   <= n_row;
            r_col   <= n_col;
            r_attr  <= n_attr;
            r_esc   <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_fill <= n_fill;
        r_last <= n_last;
        r_rch  <= n_rch;
        r_rat  <= n_rat;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cells[w_waddr] <= w_wdata;
        end
        r_rdata <= r_cells[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= r_rch;
            r_out_attr <= r_rat;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;

endmodule
`default_nettype wire

/* rtl/core/text_console_writer.sv */
// Each input word is queued; the back-end sequencer pops it, executes it (a read also
// waits on the registered cell store read) and registers the result. It takes one word
// at a time (one cell store port), popping the next once the last result is emitted;
// a put that scrolls first blanks the new bottom row, and a clear blanks every cell.
// Reset: cursor, top row and escape flag go to zero, colour to 0x07; the cell
// store is not cleared and holds undefined data until written or cleared.
`default_nettype none
module text_console_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [tcw_pkg::KIND_W-1:0] i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]  i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]  i_read_col,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tcw_pkg::CHAR_W-1:0] o_cell_char,
    output logic [tcw_pkg::CHAR_W-1:0] o_cell_attr,
    output logic [tcw_pkg::ROW_W-1:0]  o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]  o_cursor_col
);
    import tcw_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    tcw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    tcw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_empty),
        .o_q_pop      (w_pop),
        .i_cmd        (w_cmd_out),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_row < ROW_W'(ROWS)) &&
                    ({1'b0, o_cursor_col} < (COL_W + 1)'(COLS)))
        else $error("cursor outside screen");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_push))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_empty && w_pop))
        else $error("queue read while empty");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STEP = 1 << TAB_SHIFT;

    typedef struct {
        t_op               op;
        logic [CHAR_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        bit                drain_first;
    } t_console_word;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] attr;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_cell_report;

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    logic [KIND_W-1:0] i_kind       = '0;
    logic [CHAR_W-1:0] i_char_code  = '0;
    logic [ROW_W-1:0]  i_read_row   = '0;
    logic [COL_W-1:0]  i_read_col   = '0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    logic [CHAR_W-1:0] o_cell_char;
    logic [CHAR_W-1:0] o_cell_attr;
    logic [ROW_W-1:0]  o_cursor_row;
    logic [COL_W-1:0]  o_cursor_col;

    text_console_writer #(.COLS(COLS), .ROWS(ROWS)) dut (.*);

    // predicted console state
    logic [CELL_W-1:0] screen_mem [COLS*ROWS];
    int                top_line  = 0;
    int                crow      = 0;
    int                ccol      = 0;
    logic [CHAR_W-1:0] colour    = RESET_COLOR;
    bit                esc_armed = 1'b0;

    t_console_word pending_words [$];
    t_cell_report  awaited_reports [$];
    t_console_word cur_word;
    bit            hold_next = 1'b0;
    int            n_sent    = 0;
    int            n_results = 0;
    int            faults    = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;

    function automatic int phys_idx(int r, int c);
        return ((top_line + r) % ROWS) * COLS + c;
    endfunction

    function automatic void paint(int r, int c, logic [CHAR_W-1:0] ch);
        screen_mem[phys_idx(r, c)] = {colour, ch};
    endfunction

    function automatic void line_feed();
        ccol = 0;
        if (crow + 1 >= ROWS) begin
            crow     = ROWS - 1;
            top_line = (top_line + 1) % ROWS;
            for (int c = 0; c < COLS; c++)
                paint(ROWS - 1, c, CH_SPACE);
        end else begin
            crow++;
        end
    endfunction

    function automatic void place_code(logic [CHAR_W-1:0] c);
        if (esc_armed) begin
            colour    = c;
            esc_armed = 1'b0;
            return;
        end
        case (c)
            CH_NL:  line_feed();
            CH_CR:  ccol = 0;
            CH_BS: begin
                if (ccol > 0) begin
                    ccol--;
                    paint(crow, ccol, CH_SPACE);
                end
            end
            CH_ESC: esc_armed = 1'b1;
            CH_TAB: begin
                ccol += TAB_STEP - (ccol % TAB_STEP);
                if (ccol >= COLS)
                    line_feed();
            end
            default: begin
                paint(crow, ccol, c);
                ccol++;
                if (ccol >= COLS)
                    line_feed();
            end
        endcase
    endfunction

    function automatic t_cell_report console_step(t_console_word w);
        t_cell_report      r;
        logic [CELL_W-1:0] v;
        r = '0;
        case (w.op)
            OP_PUT: place_code(w.code);
            OP_READ: begin
                if (w.row < ROWS && w.col < COLS) begin
                    v      = screen_mem[phys_idx(w.row, w.col)];
                    r.ch   = v[CHAR_W-1:0];
                    r.attr = v[CELL_W-1:CHAR_W];
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < COLS*ROWS; i++)
                    screen_mem[i] = {colour, CH_SPACE};
                top_line = 0;
                crow     = 0;
                ccol     = 0;
            end
            default: ;
        endcase
        r.row = ROW_W'(crow);
        r.col = COL_W'(ccol);
        return r;
    endfunction

    // stimulus building
    function automatic t_console_word any_word(t_op op);
        t_console_word w;
        w.op          = op;
        w.code        = CHAR_W'($urandom_range(0, 255));
        w.row         = ROW_W'($urandom_range(0, 31));
        w.col         = COL_W'($urandom_range(0, 127));
        w.drain_first = 1'b0;
        return w;
    endfunction

    task automatic push_word(t_console_word w);
        w.drain_first = hold_next;
        hold_next     = 1'b0;
        pending_words.push_back(w);
    endtask

    task automatic add_put(logic [CHAR_W-1:0] c);
        t_console_word w;
        w      = any_word(OP_PUT);
        w.code = c;
        push_word(w);
    endtask

    task automatic add_read(int r, int c);
        t_console_word w;
        w     = any_word(OP_READ);
        w.row = ROW_W'(r);
        w.col = COL_W'(c);
        push_word(w);
    endtask

    task automatic add_text_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            add_put(CHAR_W'($urandom_range(8'h20, 8'h7E)));
        else if (pick < 85)
            add_put(CH_TAB);
        else if (pick < 90)
            add_put(CH_BS);
        else if (pick < 93) begin
            add_put(CH_ESC);
            add_put(CHAR_W'($urandom_range(0, 255)));
        end else
            add_put(CHAR_W'($urandom_range(0, 255)));
    endtask

    task automatic add_random_read();
        if ($urandom_range(0, 99) < 15) begin
            push_word(any_word(OP_READ));
        end else begin
            add_read(($urandom_range(0, 99) < 30) ? ROWS - 1 : $urandom_range(0, ROWS - 1),
                     $urandom_range(0, COLS - 1));
        end
    endtask

    task automatic build_stimulus();
        int seg;
        int len;
        t_console_word w;
        // directed: nothing reads the store before the first clear
        push_word(any_word(OP_NOP));
        add_read(31, 127);
        push_word(any_word(OP_CLEAR));
        add_read(0, 0);
        add_put(8'h41);
        add_put(8'h00);
        add_put(8'hFF);
        add_put(CH_BS);
        add_read(0, 1);
        add_put(CH_CR);
        add_put(CH_BS);
        add_put(CH_TAB);
        add_put(CH_ESC);
        add_put(8'h1E);
        add_put(CH_ESC);
        add_put(CH_ESC);
        add_put(8'h78);
        add_read(0, 8);
        add_put(CH_NL);
        add_read(ROWS - 1, COLS - 1);
        add_read(ROWS, 0);
        add_read(0, COLS);
        add_put(CH_ESC);
        push_word(any_word(OP_CLEAR));
        add_put(8'h4F);
        add_read(ROWS - 1, COLS - 1);

        // random: mostly lines of text with reads mixed in
        hold_next = 1'b1;
        while (pending_words.size() < 625) begin
            if (pending_words.size() > 450 && pending_words.size() < 455)
                hold_next = 1'b1;
            seg = $urandom_range(0, 99);
            if (seg < 45) begin
                len = $urandom_range(0, 90);
                repeat (len) begin
                    add_text_code();
                    if ($urandom_range(0, 99) < 25)
                        add_random_read();
                end
                add_put(($urandom_range(0, 99) < 80) ? CH_NL : CH_CR);
            end else if (seg < 70) begin
                repeat ($urandom_range(1, 6)) add_random_read();
            end else if (seg < 80) begin
                repeat ($urandom_range(1, 30)) add_put(CH_NL);
            end else if (seg < 85) begin
                add_put(CH_ESC);
                add_put(CHAR_W'($urandom_range(0, 255)));
            end else if (seg < 87) begin
                push_word(any_word(OP_CLEAR));
            end else if (seg < 90) begin
                push_word(any_word(OP_NOP));
            end else begin
                w = any_word(t_op'($urandom_range(0, 3)));
                if (w.op == OP_CLEAR)
                    w.op = OP_PUT;
                push_word(w);
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        int  sent_now;
        bit  idle;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            sent_now = n_sent;
            if (i_valid && !o_stall) begin
                awaited_reports.push_back(console_step(cur_word));
                sent_now++;
                n_sent <= sent_now;
            end
            if (!i_valid || !o_stall) begin
                idle = !(sent_now >= 300 && sent_now < 400) && $urandom_range(0, 99) < 38;
                if (pending_words.size() > 0 && !idle &&
                    !(pending_words[0].drain_first && n_results != sent_now)) begin
                    cur_word     = pending_words.pop_front();
                    i_valid     <= 1'b1;
                    i_kind      <= cur_word.op;
                    i_char_code <= cur_word.code;
                    i_read_row  <= cur_word.row;
                    i_read_col  <= cur_word.col;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && n_results >= 200) begin
            hold_done <= 1'b1;
            hold_left <= 250;
            i_stall   <= 1'b1;
        end else if (n_results >= 300 && n_results < 400) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 38);
        end
    end

    task automatic compare_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            faults++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_cell_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (n_results >= n_sent) begin
                $display("%0t: unexpected word, char %0d attr %0d cursor %0d,%0d", $time,
                         o_cell_char, o_cell_attr, o_cursor_row, o_cursor_col);
                faults++;
            end else begin
                want = awaited_reports.pop_front();
                compare_field("cell_char", want.ch, o_cell_char);
                compare_field("cell_attr", want.attr, o_cell_attr);
                compare_field("cursor_row", want.row, o_cursor_row);
                compare_field("cursor_col", want.col, o_cursor_col);
            end
            n_results <= n_results + 1;
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        build_stimulus();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_words.size() > 0 || i_valid || n_results != n_sent)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (faults == 0 && awaited_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

/* text_console_writer.f */
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
tb/sv/tb_top.sv
